@@ design/cacfar_pkg.sv @@
package cacfar_pkg;

  localparam int DEF_WINDOW_LEN = 61;
  localparam int DEF_REF_CELLS  = 50;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int THR_W       = 24;
  localparam int FRAC_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2471;

  // detect, threshold, padded to whole bytes
  localparam int TDATA_W = ((1 + THR_W + 7) / 8) * 8;

  // running sum width for a given number of reference cells
  function automatic int sum_width(input int ref_cells);
    return SAMPLE_W + $clog2(ref_cells + 1);
  endfunction

endpackage

@@ design/cacfar_queue.sv @@
module cacfar_queue
  import cacfar_pkg::*;
#(
  parameter int ITEM_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [ITEM_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [ITEM_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/cacfar_front.sv @@
module cacfar_front
  import cacfar_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int REF_CELLS  = DEF_REF_CELLS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  logic signed [SAMPLE_W-1:0]                sample,
  output logic signed [sum_width(REF_CELLS)-1:0]    sum_out,
  output logic                                      full_out,
  output logic                                      full
);

  localparam int SUM_W = sum_width(REF_CELLS);
  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic signed [SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] rd_old;
  logic signed [SAMPLE_W-1:0] rd_enter;
  logic [IDX_W-1:0]           wp;
  logic [IDX_W-1:0]           wp_next;
  logic [IDX_W:0]             enter_sum;
  logic [IDX_W-1:0]           enter_addr;
  logic [CNT_W-1:0]           fill;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;

  assign full = (fill == CNT_W'(WINDOW_LEN));

  always_comb begin
    wp_next = wp;
    if (accept) begin
      wp_next = (wp == IDX_W'(WINDOW_LEN - 1)) ? '0 : wp + 1'b1;
    end
    enter_sum = {1'b0, wp_next} + (IDX_W + 1)'(REF_CELLS);
    if (enter_sum >= (IDX_W + 1)'(WINDOW_LEN)) begin
      enter_addr = IDX_W'(enter_sum - (IDX_W + 1)'(WINDOW_LEN));
    end else begin
      enter_addr = IDX_W'(enter_sum);
    end
  end

  // oldest cell leaves, next joins once full; else first REF_CELLS samples add
  always_comb begin
    sum_next = sum;
    if (full) begin
      sum_next = sum - SUM_W'(rd_old) + SUM_W'(rd_enter);
    end else if ({1'b0, wp} < (IDX_W + 1)'(REF_CELLS)) begin
      sum_next = sum + SUM_W'(sample);
    end
  end

  assign sum_out  = sum_next;
  assign full_out = full || (fill == CNT_W'(WINDOW_LEN - 1));

  // reads target the slots for the next transfer; never the slot being written
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp] <= sample;
    end
    rd_old   <= ring[wp_next];
    rd_enter <= ring[enter_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (accept) begin
      wp  <= wp_next;
      sum <= sum_next;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

@@ design/cacfar_back.sv @@
module cacfar_back
  import cacfar_pkg::*;
#(
  parameter int REF_CELLS = DEF_REF_CELLS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [GAIN_W-1:0]                      gain,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_W-1:0]             in_sample,
  input  logic signed [sum_width(REF_CELLS)-1:0] in_sum,
  input  logic                                   in_full,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_detect,
  output logic signed [THR_W-1:0]                out_threshold,
  output logic                                   out_full
);

  localparam int SUM_W  = sum_width(REF_CELLS);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int N_W    = PROD_W - FRAC_BITS;
  localparam int U_W    = N_W - 1;
  localparam logic [U_W:0] RECIP = (U_W + 1)'((64'd1 << U_W) / REF_CELLS);
  localparam logic signed [N_W-1:0] THR_HI = N_W'((64'd1 << (THR_W - 1)) - 1);
  localparam logic signed [N_W-1:0] THR_LO = -THR_HI - N_W'(1);

  logic adv;

  logic                       v1, v2, v3, v4;
  logic signed [SAMPLE_W-1:0] s1, s2, s3, s4;
  logic                       f1, f2, f3, f4;

  logic signed [PROD_W-1:0]   prod1;
  logic signed [N_W-1:0]      n2;
  logic                       neg2c;
  logic [U_W-1:0]             u2c;
  logic [2*U_W:0]             qm2;
  logic [U_W-1:0]             qe2, u2;
  logic                       neg2;
  logic [U_W-1:0]             pq3, qe3, u3;
  logic                       neg3;
  logic [U_W-1:0]             r4;
  logic [U_W-1:0]             q4;
  logic signed [N_W-1:0]      thr4;

  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // floor division of a negative value: ~(~n / d)
  always_comb begin
    n2    = prod1[PROD_W-1:FRAC_BITS];
    neg2c = n2[N_W-1];
    u2c   = neg2c ? ~n2[U_W-1:0] : n2[U_W-1:0];
    qm2   = (2*U_W + 1)'(u2c) * (2*U_W + 1)'(RECIP);
    r4    = u3 - pq3;
    q4    = (r4 >= U_W'(REF_CELLS)) ? qe3 + 1'b1 : qe3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= in_sample;
      f1    <= in_full;
      prod1 <= PROD_W'(in_sum) * PROD_W'($signed({1'b0, gain}));

      s2   <= s1;
      f2   <= f1;
      u2   <= u2c;
      neg2 <= neg2c;
      qe2  <= qm2[U_W +: U_W];

      s3   <= s2;
      f3   <= f2;
      u3   <= u2;
      neg3 <= neg2;
      qe3  <= qe2;
      pq3  <= U_W'(qe2 * U_W'(REF_CELLS));

      s4   <= s3;
      f4   <= f3;
      thr4 <= neg3 ? ~$signed({1'b0, q4}) : $signed({1'b0, q4});

      out_full   <= f4;
      out_detect <= (N_W'(s4) > thr4);
      if (thr4 > THR_HI) begin
        out_threshold <= THR_W'(THR_HI);
      end else if (thr4 < THR_LO) begin
        out_threshold <= THR_W'(THR_LO);
      end else begin
        out_threshold <= THR_W'(thr4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

@@ design/cell_average_cfar_detector.sv @@
// an input transfer is queued, then passes the threshold pipeline to m_tvalid
// throughput: one sample per cycle while the four-entry queue has room; ring and
//   running sum update on accept; threshold math is a five-stage pipeline past the queue
// reset (rst, synchronous): pointers, fill count, running sum, queue and pipeline
//   cleared, gain back to 2471; ring slot values are not used before the window fills
module cell_average_cfar_detector
  import cacfar_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int REF_CELLS  = DEF_REF_CELLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // sample
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // detect, threshold, zero pad
  output logic               m_tuser,   // window_full
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data   // alpha_gain
);

  localparam int SUM_W  = sum_width(REF_CELLS);
  localparam int ITEM_W = SAMPLE_W + SUM_W + 1;

  logic [GAIN_W-1:0]          gain;
  logic                       accept;
  logic signed [SUM_W-1:0]    fr_sum;
  logic                       fr_full_out;
  logic                       fr_full;
  logic                       q_valid;
  logic                       q_ready;
  logic [ITEM_W-1:0]          q_data;
  logic                       out_detect;
  logic signed [THR_W-1:0]    out_threshold;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  cacfar_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .REF_CELLS  (REF_CELLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample   ($signed(s_tdata)),
    .sum_out  (fr_sum),
    .full_out (fr_full_out),
    .full     (fr_full)
  );

  cacfar_queue #(
    .ITEM_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  ({fr_full_out, fr_sum, s_tdata}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cacfar_back #(
    .REF_CELLS (REF_CELLS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .gain          (gain),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_sample     ($signed(q_data[SAMPLE_W-1:0])),
    .in_sum        ($signed(q_data[SAMPLE_W +: SUM_W])),
    .in_full       (q_data[ITEM_W-1]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_detect    (out_detect),
    .out_threshold (out_threshold),
    .out_full      (m_tuser)
  );

  assign m_tdata = {(TDATA_W - THR_W - 1)'(0), out_threshold, out_detect};

`ifndef NO_ASSERTIONS
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    fr_full |=> fr_full)
    else $error("window fill flag dropped");

  a_out_full_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser |=> !m_tvalid || m_tuser)
    else $error("result after a full window reports window not full");

  a_detect_below_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> $signed(m_tdata[THR_W:1]) < $signed(THR_W'(32767)))
    else $error("detect set with threshold at or above sample range");
`endif

endmodule
